// ===== src/bcdt_pkg.sv =====
package bcdt_pkg;

    localparam int unsigned DIGIT_W   = 4;
    localparam int unsigned REQ_W     = 3;
    localparam int unsigned PHASE_W   = 3;
    localparam int unsigned LIMIT_W   = 13;
    localparam int unsigned TOTAL_W   = 14;

    // bcd digit limits for the borrow chain
    localparam logic [DIGIT_W-1:0] DIGIT_MAX    = 4'd9;
    localparam logic [DIGIT_W-1:0] SEC_TENS_MAX = 4'd5;
    localparam logic [DIGIT_W-1:0] DIGIT_ZERO   = 4'd0;

    // seconds weight of each digit position
    localparam logic [TOTAL_W-1:0] W_MIN_TENS  = 14'd600;
    localparam logic [TOTAL_W-1:0] W_MIN_UNITS = 14'd60;
    localparam logic [TOTAL_W-1:0] W_SEC_TENS  = 14'd10;

    // limit after reset: thirty minutes
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'(30 * 60);

    // request codes
    localparam logic [REQ_W-1:0] REQ_LOAD        = 3'd0;
    localparam logic [REQ_W-1:0] REQ_TICK        = 3'd1;
    localparam logic [REQ_W-1:0] REQ_SWITCH1     = 3'd2;
    localparam logic [REQ_W-1:0] REQ_SWITCH2     = 3'd3;
    localparam logic [REQ_W-1:0] REQ_DOOR_OPEN   = 3'd4;
    localparam logic [REQ_W-1:0] REQ_DOOR_CLOSED = 3'd5;

    typedef enum logic [PHASE_W-1:0] {
        PH_IDLE        = 3'd0,
        PH_RUN         = 3'd1,
        PH_PAUSE       = 3'd2,
        PH_DOOR_OPEN   = 3'd3,
        PH_DOOR_CLOSED = 3'd4
    } phase_t;

    typedef struct packed {
        logic [DIGIT_W-1:0] min_tens;
        logic [DIGIT_W-1:0] min_units;
        logic [DIGIT_W-1:0] sec_tens;
        logic [DIGIT_W-1:0] sec_units;
    } count_t;

    typedef struct packed {
        phase_t phase;
        count_t count;
    } state_t;

    typedef struct packed {
        logic digit_bad;
        logic over_limit;
    } load_chk_t;

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [DIGIT_W-1:0] load_min_tens;
        logic [DIGIT_W-1:0] load_min_units;
        logic [DIGIT_W-1:0] load_sec_tens;
        logic [DIGIT_W-1:0] load_sec_units;
    } req_item_t;

    typedef struct packed {
        logic [DIGIT_W-1:0] shown_min_tens;
        logic [DIGIT_W-1:0] shown_min_units;
        logic [DIGIT_W-1:0] shown_sec_tens;
        logic [DIGIT_W-1:0] shown_sec_units;
        logic [PHASE_W-1:0] phase_now;
        logic               alarm_pulse;
        logic               load_error;
    } rsp_item_t;

endpackage

// ===== src/bcdt_if.sv =====
interface bcdt_req_if;
    import bcdt_pkg::*;

    logic      valid;
    logic      ready;
    req_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface bcdt_rsp_if;
    import bcdt_pkg::*;

    logic      valid;
    logic      ready;
    rsp_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/bcdt_load_check.sv =====
module bcdt_load_check (
    input  bcdt_pkg::req_item_t                 item,
    input  logic [bcdt_pkg::LIMIT_W-1:0]        limit,
    output bcdt_pkg::load_chk_t                 chk
);
    import bcdt_pkg::*;

    logic [TOTAL_W-1:0] total;

    // any digit above nine is bad
    always_comb
    begin
        chk.digit_bad = (item.load_min_tens > DIGIT_MAX) || (item.load_min_units > DIGIT_MAX)
                     || (item.load_sec_tens > DIGIT_MAX) || (item.load_sec_units > DIGIT_MAX);
    end

    // total seconds against the programmed limit
    always_comb
    begin
        total = TOTAL_W'(item.load_min_tens) * W_MIN_TENS
              + TOTAL_W'(item.load_min_units) * W_MIN_UNITS
              + TOTAL_W'(item.load_sec_tens) * W_SEC_TENS
              + TOTAL_W'(item.load_sec_units);
        chk.over_limit = total > TOTAL_W'(limit);
    end

endmodule

// ===== src/bcdt_step.sv =====
module bcdt_step (
    input  bcdt_pkg::req_item_t              item,
    input  bcdt_pkg::state_t                 state,
    input  logic [bcdt_pkg::LIMIT_W-1:0]     limit,
    output bcdt_pkg::state_t                 state_next,
    output bcdt_pkg::rsp_item_t              rsp
);
    import bcdt_pkg::*;

    load_chk_t chk;
    count_t    dec;
    logic      at_zero;
    logic      alarm;
    logic      err;

    bcdt_load_check u_load_check (
        .item  (item),
        .limit (limit),
        .chk   (chk)
    );

    // one-second decrement with borrow
    always_comb
    begin
        dec     = state.count;
        at_zero = 1'b0;
        if (state.count.sec_units != DIGIT_ZERO)
        begin
            dec.sec_units = state.count.sec_units - 4'd1;
        end
        else if (state.count.sec_tens != DIGIT_ZERO)
        begin
            dec.sec_tens  = state.count.sec_tens - 4'd1;
            dec.sec_units = DIGIT_MAX;
        end
        else if (state.count.min_units != DIGIT_ZERO)
        begin
            dec.min_units = state.count.min_units - 4'd1;
            dec.sec_tens  = SEC_TENS_MAX;
            dec.sec_units = DIGIT_MAX;
        end
        else if (state.count.min_tens != DIGIT_ZERO)
        begin
            dec.min_tens  = state.count.min_tens - 4'd1;
            dec.min_units = DIGIT_MAX;
            dec.sec_tens  = SEC_TENS_MAX;
            dec.sec_units = DIGIT_MAX;
        end
        else
        begin
            at_zero = 1'b1;
        end
    end

    // phase and count update per request
    always_comb
    begin
        state_next = state;
        alarm      = 1'b0;
        err        = 1'b0;
        case (item.req_type)
            REQ_LOAD:
            begin
                if (state.phase == PH_IDLE)
                begin
                    if (!chk.digit_bad && !chk.over_limit)
                    begin
                        state_next.count.min_tens  = item.load_min_tens;
                        state_next.count.min_units = item.load_min_units;
                        state_next.count.sec_tens  = item.load_sec_tens;
                        state_next.count.sec_units = item.load_sec_units;
                        state_next.phase           = PH_RUN;
                    end
                    else
                    begin
                        err = 1'b1;
                    end
                end
            end
            REQ_TICK:
            begin
                if (state.phase == PH_RUN)
                begin
                    if (at_zero)
                    begin
                        state_next.phase = PH_IDLE;
                        alarm            = 1'b1;
                    end
                    else
                    begin
                        state_next.count = dec;
                    end
                end
            end
            REQ_SWITCH1:
            begin
                if (state.phase == PH_RUN)
                    state_next.phase = PH_PAUSE;
                else if (state.phase == PH_PAUSE || state.phase == PH_DOOR_CLOSED)
                    state_next.phase = PH_IDLE;
            end
            REQ_SWITCH2:
            begin
                if (state.phase == PH_PAUSE || state.phase == PH_DOOR_CLOSED)
                    state_next.phase = PH_RUN;
            end
            REQ_DOOR_OPEN:
            begin
                if (state.phase == PH_RUN || state.phase == PH_PAUSE
                    || state.phase == PH_DOOR_CLOSED)
                    state_next.phase = PH_DOOR_OPEN;
            end
            REQ_DOOR_CLOSED:
            begin
                if (state.phase == PH_DOOR_OPEN)
                    state_next.phase = PH_DOOR_CLOSED;
            end
            default:
            begin
                state_next = state;
            end
        endcase
    end

    // result item from the updated state
    always_comb
    begin
        rsp.shown_min_tens  = state_next.count.min_tens;
        rsp.shown_min_units = state_next.count.min_units;
        rsp.shown_sec_tens  = state_next.count.sec_tens;
        rsp.shown_sec_units = state_next.count.sec_units;
        rsp.phase_now       = state_next.phase;
        rsp.alarm_pulse     = alarm;
        rsp.load_error      = err;
    end

endmodule

// ===== src/bcd_countdown_timer_pause_door.sv =====
// channel   dir  handshake      payload
// req       in   valid/ready    req_type, load digits (bcd mm:ss)
// rsp       out  valid/ready    shown digits, phase_now, alarm_pulse, load_error
// cfg       in   cfg_wr_en      cfg_wr_data = max_total_seconds
//
// An accepted item passes through the input register, then the result register.
// One item per cycle sustained while rsp is ready; the state update sits between the two registers.
// rst_n clears phase and digits to idle 00:00 and the limit to 1800 seconds.
// A stalled rsp holds the result; req keeps taking items until both registers are full.
module bcd_countdown_timer_pause_door (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [bcdt_pkg::LIMIT_W-1:0]  cfg_wr_data,
    bcdt_req_if.sink                      req,
    bcdt_rsp_if.source                    rsp
);
    import bcdt_pkg::*;

    req_item_t            req_item_reg;
    logic                 req_valid_reg;
    state_t               state_reg;
    state_t               state_next;
    logic [LIMIT_W-1:0]   limit_reg;
    rsp_item_t            rsp_item_reg;
    rsp_item_t            rsp_item_next;
    logic                 rsp_valid_reg;
    logic                 advance;

    // move the held item into the result register when it has room
    assign advance   = req_valid_reg && (!rsp_valid_reg || rsp.ready);
    assign req.ready = !req_valid_reg || advance;

    assign rsp.valid   = rsp_valid_reg;
    assign rsp.payload = rsp_item_reg;

    bcdt_step u_step (
        .item       (req_item_reg),
        .state      (state_reg),
        .limit      (limit_reg),
        .state_next (state_next),
        .rsp        (rsp_item_next)
    );

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
            state_reg     <= '{phase: PH_IDLE, count: '0};
            limit_reg     <= LIMIT_RESET;
        end
        else
        begin
            if (cfg_wr_en)
                limit_reg <= cfg_wr_data;
            if (req.ready)
                req_valid_reg <= req.valid;
            if (advance)
            begin
                state_reg     <= state_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
            req_item_reg <= req.payload;
        if (advance)
            rsp_item_reg <= rsp_item_next;
    end

endmodule

// ===== src/bcdt_checker.sv =====
module bcdt_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input bcdt_pkg::rsp_item_t           rsp_payload
);
    import bcdt_pkg::*;

    // a stalled result holds still
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
        else $error("result changed while stalled");

    // alarm and load error never come together
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp_payload.alarm_pulse && rsp_payload.load_error))
        else $error("alarm and load error together");

    // alarm leaves the timer idle at 00:00
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_payload.alarm_pulse |->
            rsp_payload.phase_now == PH_IDLE && rsp_payload.shown_min_tens == DIGIT_ZERO
            && rsp_payload.shown_min_units == DIGIT_ZERO
            && rsp_payload.shown_sec_tens == DIGIT_ZERO
            && rsp_payload.shown_sec_units == DIGIT_ZERO)
        else $error("alarm with nonzero count or not idle");

    // a rejected load stays idle
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_payload.load_error |-> rsp_payload.phase_now == PH_IDLE)
        else $error("load error outside idle");

    // shown digits are always valid bcd
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_payload.shown_min_tens <= DIGIT_MAX
            && rsp_payload.shown_min_units <= DIGIT_MAX
            && rsp_payload.shown_sec_tens <= DIGIT_MAX
            && rsp_payload.shown_sec_units <= DIGIT_MAX)
        else $error("shown digit above nine");

endmodule

bind bcd_countdown_timer_pause_door bcdt_checker u_bcdt_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_payload (rsp.payload)
);

// ===== tb/tb_bcd_countdown_timer_pause_door.sv =====
module tb_bcd_countdown_timer_pause_door;
    import bcdt_pkg::*;

    localparam int QUIET_LIMIT  = 2000;
    localparam int HOLD_AT      = 380;
    localparam int HOLD_CYCLES  = 200;
    localparam int CALM_FROM    = 500;
    localparam int CALM_TO      = 620;
    localparam int PHASE_ITEMS  = 145;
    localparam int SETTLE       = 4;
    localparam int PRINT_CAP    = 50;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [LIMIT_W-1:0]   cfg_wr_data;

    bcdt_req_if req_ch ();
    bcdt_rsp_if rsp_ch ();

    bcd_countdown_timer_pause_door u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_ch),
        .rsp         (rsp_ch)
    );

    // timer state as the testbench sees it
    phase_t             tm_phase = PH_IDLE;
    count_t             tm_count = '0;
    logic [LIMIT_W-1:0] tm_limit = LIMIT_RESET;

    req_item_t pending_reqs[$];
    rsp_item_t expected_readouts[$];

    int queued_total   = 0;
    int offered_count  = 0;
    int taken_count    = 0;
    int readouts_seen  = 0;
    int mismatch_count = 0;
    int quiet_cycles   = 0;
    int hold_left      = 0;
    bit hold_done      = 1'b0;

    // clock
    initial clk = 1'b0;
    always
    begin
        #4 clk = ~clk;
    end

    // advance the timer by one item and return the readout it should produce
    function automatic rsp_item_t advance_timer(req_item_t it);
        rsp_item_t   r;
        logic        alarm;
        logic        err;
        logic        digits_ok;
        int unsigned total;
        alarm = 1'b0;
        err   = 1'b0;
        case (it.req_type)
            REQ_LOAD:
            begin
                if (tm_phase == PH_IDLE)
                begin
                    digits_ok = it.load_min_tens <= DIGIT_MAX && it.load_min_units <= DIGIT_MAX
                             && it.load_sec_tens <= DIGIT_MAX && it.load_sec_units <= DIGIT_MAX;
                    total = it.load_min_tens * 600 + it.load_min_units * 60
                          + it.load_sec_tens * 10 + it.load_sec_units;
                    if (digits_ok && total <= tm_limit)
                    begin
                        tm_count.min_tens  = it.load_min_tens;
                        tm_count.min_units = it.load_min_units;
                        tm_count.sec_tens  = it.load_sec_tens;
                        tm_count.sec_units = it.load_sec_units;
                        tm_phase = PH_RUN;
                    end
                    else
                    begin
                        err = 1'b1;
                    end
                end
            end
            REQ_TICK:
            begin
                // borrow chain, zero count ends the run
                if (tm_phase == PH_RUN)
                begin
                    if (tm_count.sec_units != DIGIT_ZERO)
                    begin
                        tm_count.sec_units = tm_count.sec_units - 1'b1;
                    end
                    else if (tm_count.sec_tens != DIGIT_ZERO)
                    begin
                        tm_count.sec_tens  = tm_count.sec_tens - 1'b1;
                        tm_count.sec_units = DIGIT_MAX;
                    end
                    else if (tm_count.min_units != DIGIT_ZERO)
                    begin
                        tm_count.min_units = tm_count.min_units - 1'b1;
                        tm_count.sec_tens  = SEC_TENS_MAX;
                        tm_count.sec_units = DIGIT_MAX;
                    end
                    else if (tm_count.min_tens != DIGIT_ZERO)
                    begin
                        tm_count.min_tens  = tm_count.min_tens - 1'b1;
                        tm_count.min_units = DIGIT_MAX;
                        tm_count.sec_tens  = SEC_TENS_MAX;
                        tm_count.sec_units = DIGIT_MAX;
                    end
                    else
                    begin
                        tm_phase = PH_IDLE;
                        alarm    = 1'b1;
                    end
                end
            end
            REQ_SWITCH1:
            begin
                if (tm_phase == PH_RUN)
                    tm_phase = PH_PAUSE;
                else if (tm_phase == PH_PAUSE || tm_phase == PH_DOOR_CLOSED)
                    tm_phase = PH_IDLE;
            end
            REQ_SWITCH2:
            begin
                if (tm_phase == PH_PAUSE || tm_phase == PH_DOOR_CLOSED)
                    tm_phase = PH_RUN;
            end
            REQ_DOOR_OPEN:
            begin
                if (tm_phase == PH_RUN || tm_phase == PH_PAUSE || tm_phase == PH_DOOR_CLOSED)
                    tm_phase = PH_DOOR_OPEN;
            end
            REQ_DOOR_CLOSED:
            begin
                if (tm_phase == PH_DOOR_OPEN)
                    tm_phase = PH_DOOR_CLOSED;
            end
            default:
            begin
            end
        endcase
        r.shown_min_tens  = tm_count.min_tens;
        r.shown_min_units = tm_count.min_units;
        r.shown_sec_tens  = tm_count.sec_tens;
        r.shown_sec_units = tm_count.sec_units;
        r.phase_now       = tm_phase;
        r.alarm_pulse     = alarm;
        r.load_error      = err;
        return r;
    endfunction

    task automatic report_mismatch(string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("readout %0d: %s", readouts_seen, what);
    endtask

    task automatic compare_readout(rsp_item_t got, rsp_item_t want);
        if (got.shown_min_tens !== want.shown_min_tens)
            report_mismatch($sformatf("shown_min_tens %0h, expected %0h",
                                      got.shown_min_tens, want.shown_min_tens));
        if (got.shown_min_units !== want.shown_min_units)
            report_mismatch($sformatf("shown_min_units %0h, expected %0h",
                                      got.shown_min_units, want.shown_min_units));
        if (got.shown_sec_tens !== want.shown_sec_tens)
            report_mismatch($sformatf("shown_sec_tens %0h, expected %0h",
                                      got.shown_sec_tens, want.shown_sec_tens));
        if (got.shown_sec_units !== want.shown_sec_units)
            report_mismatch($sformatf("shown_sec_units %0h, expected %0h",
                                      got.shown_sec_units, want.shown_sec_units));
        if (got.phase_now !== want.phase_now)
            report_mismatch($sformatf("phase_now %0h, expected %0h",
                                      got.phase_now, want.phase_now));
        if (got.alarm_pulse !== want.alarm_pulse)
            report_mismatch($sformatf("alarm_pulse %0b, expected %0b",
                                      got.alarm_pulse, want.alarm_pulse));
        if (got.load_error !== want.load_error)
            report_mismatch($sformatf("load_error %0b, expected %0b",
                                      got.load_error, want.load_error));
    endtask

    function automatic logic [DIGIT_W-1:0] rnd_digit();
        return DIGIT_W'($urandom_range(0, 15));
    endfunction

    task automatic push_req(logic [REQ_W-1:0] kind, logic [DIGIT_W-1:0] mt,
                            logic [DIGIT_W-1:0] mu, logic [DIGIT_W-1:0] st,
                            logic [DIGIT_W-1:0] su);
        req_item_t it;
        it.req_type       = kind;
        it.load_min_tens  = mt;
        it.load_min_units = mu;
        it.load_sec_tens  = st;
        it.load_sec_units = su;
        pending_reqs.push_back(it);
        queued_total++;
    endtask

    // non-load request with junk in the digit fields
    task automatic queue_event(logic [REQ_W-1:0] kind);
        push_req(kind, rnd_digit(), rnd_digit(), rnd_digit(), rnd_digit());
    endtask

    // loads are mostly short so that countdowns reach the alarm
    task automatic queue_load();
        case ($urandom_range(0, 9))
            0: push_req(REQ_LOAD, rnd_digit(), rnd_digit(), rnd_digit(), rnd_digit());
            1: push_req(REQ_LOAD, 4'($urandom_range(0, 9)), 4'($urandom_range(0, 9)),
                        4'($urandom_range(0, 9)), 4'($urandom_range(0, 9)));
            2: push_req(REQ_LOAD, 4'($urandom_range(0, 1)), 4'($urandom_range(0, 1)),
                        DIGIT_ZERO, 4'($urandom_range(0, 1)));
            3: push_req(REQ_LOAD, DIGIT_ZERO, DIGIT_ZERO, 4'($urandom_range(6, 9)),
                        4'($urandom_range(0, 9)));
            default: push_req(REQ_LOAD, DIGIT_ZERO, DIGIT_ZERO, 4'($urandom_range(0, 1)),
                              4'($urandom_range(0, 9)));
        endcase
    endtask

    // a load followed by a run of ticks, pauses, stops and door events
    task automatic queue_session();
        int n_events;
        int e;
        int k;
        queue_load();
        n_events = $urandom_range(5, 30);
        repeat (n_events)
        begin
            e = $urandom_range(0, 99);
            if (e < 60)
            begin
                queue_event(REQ_TICK);
            end
            else if (e < 68)
            begin
                // pause, then resume or stop
                queue_event(REQ_SWITCH1);
                k = $urandom_range(0, 2);
                repeat (k) queue_event(REQ_TICK);
                queue_event(($urandom_range(0, 3) == 0) ? REQ_SWITCH1 : REQ_SWITCH2);
            end
            else if (e < 76)
            begin
                // door open, ignored requests, door closed, then a switch
                queue_event(REQ_DOOR_OPEN);
                k = $urandom_range(0, 2);
                repeat (k)
                begin
                    case ($urandom_range(0, 3))
                        0: queue_event(REQ_TICK);
                        1: queue_event(REQ_SWITCH1);
                        2: queue_event(REQ_SWITCH2);
                        default: queue_event(REQ_DOOR_OPEN);
                    endcase
                end
                queue_event(REQ_DOOR_CLOSED);
                queue_event(($urandom_range(0, 3) == 0) ? REQ_SWITCH1 : REQ_SWITCH2);
            end
            else if (e < 82)
                queue_event(REQ_SWITCH2);
            else if (e < 87)
                queue_event(REQ_SWITCH1);
            else if (e < 91)
                queue_event(REQ_DOOR_OPEN);
            else if (e < 95)
                queue_event(REQ_DOOR_CLOSED);
            else if (e < 98)
                queue_load();
            else
                queue_event(REQ_W'($urandom_range(6, 7)));
        end
    endtask

    task automatic queue_random_items(int n);
        int target;
        target = queued_total + n;
        while (queued_total < target)
        begin
            if ($urandom_range(0, 99) < 8)
                push_req(REQ_W'($urandom_range(0, 7)), rnd_digit(), rnd_digit(),
                         rnd_digit(), rnd_digit());
            else
                queue_session();
        end
    endtask

    // wait until every queued request is sent and every readout is back
    task automatic wait_drained();
        while (pending_reqs.size() > 0 || req_ch.valid || expected_readouts.size() > 0)
            @(posedge clk);
    endtask

    task automatic write_limit(logic [LIMIT_W-1:0] value);
        wait_drained();
        repeat (SETTLE) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        tm_limit = value;
    endtask

    // request driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_ch.valid   <= 1'b0;
            req_ch.payload <= '0;
        end
        else if (!req_ch.valid || req_ch.ready)
        begin
            if (pending_reqs.size() > 0 &&
                ((offered_count >= CALM_FROM && offered_count < CALM_TO) ||
                 $urandom_range(0, 99) >= 13))
            begin
                req_ch.payload <= pending_reqs.pop_front();
                req_ch.valid   <= 1'b1;
                offered_count++;
            end
            else
            begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // readout receiver, with one long hold-off
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
                taken_count++;
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (!hold_done && taken_count >= HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= (taken_count >= CALM_FROM && taken_count < CALM_TO) ||
                                ($urandom_range(0, 99) >= 13);
            end
        end
    end

    // check readouts, then predict for the item taken at this edge
    always @(posedge clk)
    begin : readout_check
        rsp_item_t want;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_readouts.size() == 0)
                begin
                    report_mismatch("readout with no item waiting for it");
                end
                else
                begin
                    want = expected_readouts.pop_front();
                    compare_readout(rsp_ch.payload, want);
                end
                readouts_seen++;
            end
            if (req_ch.valid && req_ch.ready)
                expected_readouts.push_back(advance_timer(req_ch.payload));
        end
    end

    // watchdog on cycles with no item moving
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // stimulus sequence
    initial
    begin
        rst_n          = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        req_ch.valid   = 1'b0;
        req_ch.payload = '0;
        rsp_ch.ready   = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // every non-load request in idle, then an unused code
        queue_event(REQ_TICK);
        queue_event(REQ_SWITCH1);
        queue_event(REQ_SWITCH2);
        queue_event(REQ_DOOR_OPEN);
        queue_event(REQ_DOOR_CLOSED);
        push_req(REQ_W'(7), 4'hF, 4'hF, 4'hF, 4'hF);
        // load exactly at the reset limit, then load while running is ignored
        push_req(REQ_LOAD, 4'd3, 4'd0, 4'd0, 4'd0);
        push_req(REQ_LOAD, 4'd0, 4'd0, 4'd0, 4'd1);
        queue_event(REQ_TICK);
        // pause, tick ignored, resume
        queue_event(REQ_SWITCH1);
        queue_event(REQ_TICK);
        queue_event(REQ_SWITCH2);
        // door interlock: a switch ignored while open, reopen from closed wait
        queue_event(REQ_DOOR_OPEN);
        queue_event(REQ_SWITCH2);
        queue_event(REQ_DOOR_CLOSED);
        queue_event(REQ_DOOR_OPEN);
        queue_event(REQ_DOOR_CLOSED);
        queue_event(REQ_SWITCH1);
        // rejected loads: one second over the limit, digit of ten
        push_req(REQ_LOAD, 4'd3, 4'd0, 4'd0, 4'd1);
        push_req(REQ_LOAD, 4'd0, 4'd0, 4'd10, 4'd0);
        // borrow across every digit, then pause and stop
        push_req(REQ_LOAD, 4'd1, 4'd0, 4'd0, 4'd0);
        queue_event(REQ_TICK);
        queue_event(REQ_SWITCH1);
        queue_event(REQ_SWITCH1);
        // zero load: first tick rings the alarm
        push_req(REQ_LOAD, 4'd0, 4'd0, 4'd0, 4'd0);
        queue_event(REQ_TICK);

        queue_random_items(PHASE_ITEMS);
        write_limit('0);
        queue_random_items(PHASE_ITEMS);
        write_limit(LIMIT_W'(5999));
        queue_random_items(PHASE_ITEMS);
        write_limit(LIMIT_W'(4095));
        queue_random_items(PHASE_ITEMS);
        write_limit(LIMIT_W'($urandom_range(1, 5998)));
        queue_random_items(PHASE_ITEMS);

        wait_drained();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/bcdt_pkg.sv
src/bcdt_if.sv
src/bcdt_load_check.sv
src/bcdt_step.sv
src/bcd_countdown_timer_pause_door.sv
src/bcdt_checker.sv
tb/tb_bcd_countdown_timer_pause_door.sv
